// File: rtl/ps2kb_pkg.sv
package ps2kb_pkg;

  // item kinds on the input channel
  localparam logic [1:0] CMD_KEY  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_HOST = 2'd2;

  // bytes sent to the host
  localparam logic [7:0] BYTE_EXT   = 8'hE0;
  localparam logic [7:0] BYTE_BREAK = 8'hF0;
  localparam logic [7:0] RSP_ACK    = 8'hFA;
  localparam logic [7:0] RSP_BAT_OK = 8'hAA;
  localparam logic [7:0] RSP_ID0    = 8'hAB;
  localparam logic [7:0] RSP_ID1    = 8'h83;
  localparam logic [7:0] RSP_ECHO   = 8'hEE;

  // host commands
  localparam logic [7:0] HCMD_NOP      = 8'h00;
  localparam logic [7:0] HCMD_RESET    = 8'hFF;
  localparam logic [7:0] HCMD_RESEND   = 8'hFE;
  localparam logic [7:0] HCMD_RATE     = 8'hF3;
  localparam logic [7:0] HCMD_SCAN_SET = 8'hF0;
  localparam logic [7:0] HCMD_LEDS     = 8'hED;
  localparam logic [7:0] HCMD_READ_ID  = 8'hF2;
  localparam logic [7:0] HCMD_ECHO     = 8'hEE;

  // modifier keys, normal set
  localparam logic [7:0] KEY_LCTRL  = 8'h14;
  localparam logic [7:0] KEY_LSHIFT = 8'h12;
  localparam logic [7:0] KEY_LALT   = 8'h11;
  localparam logic [7:0] KEY_RSHIFT = 8'h59;
  // modifier keys, E0 set
  localparam logic [7:0] KEY_LGUI   = 8'h1F;
  localparam logic [7:0] KEY_RGUI   = 8'h27;

  localparam int unsigned MAX_BYTES = 3;

  typedef enum logic [2:0] {
    TM_IDLE   = 3'b001,
    TM_DELAY  = 3'b010,
    TM_REPEAT = 3'b100
  } tm_mode_t;

  typedef struct packed {
    tm_mode_t    mode;
    logic [3:0]  delay_cnt;
    logic [7:0]  held_code;
    logic        held_ext;
    logic [7:0]  last_code;
    logic        last_ext;
    logic        last_pressed;
    logic        param_pend;
  } kb_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] key_code;
    logic       key_extended;
    logic       key_pressed;
    logic [7:0] host_byte;
    logic       host_parity_ok;
  } kb_item_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [1:0]                cnt;
  } kb_burst_t;

  function automatic logic is_modifier(input logic [7:0] code, input logic ext);
    if (ext)
      return code == KEY_LGUI || code == KEY_LCTRL || code == KEY_LALT || code == KEY_RGUI;
    return code == KEY_LCTRL || code == KEY_LSHIFT || code == KEY_LALT || code == KEY_RSHIFT;
  endfunction

endpackage

// File: rtl/ps2kb_decode.sv
module ps2kb_decode
  import ps2kb_pkg::*;
(
  input  kb_item_t   item,
  input  kb_state_t  st,
  input  logic [3:0] repeat_delay,
  output kb_state_t  st_nxt,
  output kb_burst_t  burst
);

  logic       do_key;
  logic [7:0] ev_code;
  logic       ev_ext;
  logic       ev_pressed;
  logic [3:0] dc_inc;

  always_comb begin
    st_nxt      = st;
    burst.bytes = '0;
    burst.cnt   = 2'd0;
    do_key      = 1'b0;
    ev_code     = item.key_code;
    ev_ext      = item.key_extended;
    ev_pressed  = item.key_pressed;
    dc_inc      = st.delay_cnt + 4'd1;

    case (item.cmd)
      CMD_KEY: begin
        do_key = 1'b1;
      end
      CMD_TICK: begin
        case (st.mode)
          TM_DELAY: begin
            if (dc_inc == repeat_delay) begin
              st_nxt.mode      = TM_REPEAT;
              st_nxt.delay_cnt = 4'd0;
            end else begin
              st_nxt.delay_cnt = dc_inc;
            end
          end
          TM_REPEAT: begin
            if (st.held_ext) begin
              burst.bytes[0] = BYTE_EXT;
              burst.bytes[1] = st.held_code;
              burst.cnt      = 2'd2;
            end else begin
              burst.bytes[0] = st.held_code;
              burst.cnt      = 2'd1;
            end
          end
          default: begin
            st_nxt.delay_cnt = 4'd0;
          end
        endcase
      end
      CMD_HOST: begin
        if (st.param_pend) begin
          // parameter byte: value dropped, ack only on good parity
          st_nxt.param_pend = 1'b0;
          if (item.host_parity_ok) begin
            burst.bytes[0] = RSP_ACK;
            burst.cnt      = 2'd1;
          end
        end else begin
          case (item.host_byte)
            HCMD_NOP: begin
            end
            HCMD_RESET: begin
              burst.bytes[0] = RSP_ACK;
              burst.bytes[1] = RSP_BAT_OK;
              burst.cnt      = 2'd2;
            end
            HCMD_RESEND: begin
              do_key     = 1'b1;
              ev_code    = st.last_code;
              ev_ext     = st.last_ext;
              ev_pressed = st.last_pressed;
            end
            HCMD_RATE, HCMD_SCAN_SET, HCMD_LEDS: begin
              burst.bytes[0]    = RSP_ACK;
              burst.cnt         = 2'd1;
              st_nxt.param_pend = 1'b1;
            end
            HCMD_READ_ID: begin
              burst.bytes[0] = RSP_ACK;
              burst.bytes[1] = RSP_ID0;
              burst.bytes[2] = RSP_ID1;
              burst.cnt      = 2'd3;
            end
            HCMD_ECHO: begin
              burst.bytes[0] = RSP_ECHO;
              burst.cnt      = 2'd1;
            end
            default: begin
              burst.bytes[0] = RSP_ACK;
              burst.cnt      = 2'd1;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    if (do_key) begin
      st_nxt.last_code    = ev_code;
      st_nxt.last_ext     = ev_ext;
      st_nxt.last_pressed = ev_pressed;
      if (ev_pressed) begin
        if (ev_ext) begin
          burst.bytes[0] = BYTE_EXT;
          burst.bytes[1] = ev_code;
          burst.cnt      = 2'd2;
        end else begin
          burst.bytes[0] = ev_code;
          burst.cnt      = 2'd1;
        end
        // delay count deliberately kept on re-press
        if (!is_modifier(ev_code, ev_ext)) begin
          st_nxt.held_code = ev_code;
          st_nxt.held_ext  = ev_ext;
          st_nxt.mode      = TM_DELAY;
        end
      end else begin
        if (ev_ext) begin
          burst.bytes[0] = BYTE_EXT;
          burst.bytes[1] = BYTE_BREAK;
          burst.bytes[2] = ev_code;
          burst.cnt      = 2'd3;
        end else begin
          burst.bytes[0] = BYTE_BREAK;
          burst.bytes[1] = ev_code;
          burst.cnt      = 2'd2;
        end
        if (ev_code == st.held_code && ev_ext == st.held_ext) begin
          st_nxt.held_code = 8'h00;
          st_nxt.mode      = TM_IDLE;
        end
      end
    end
  end

endmodule

// File: rtl/ps2_keyboard_event_and_command_engine.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     cmd, key code/ext/pressed, host byte, parity
// out      output     out_valid / out_ready   out_byte, out_last_of_run
// cfg      input      cfg_wr_en               cfg_wr_data (repeat delay, 4 bits)
//
// An item is decoded in the cycle it is accepted; its 0 to 3 bytes are loaded into a
// byte buffer and leave one per cycle while out_ready is high.
// The byte buffer paces the input: in_ready is high when the buffer is empty or its
// final byte goes out in this cycle. Items that yield no bytes leave the buffer empty.
// Synchronous active-low reset empties the buffer and sets the repeat delay to 4.
module ps2_keyboard_event_and_command_engine
  import ps2kb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_key_code,
  input  logic       in_key_extended,
  input  logic       in_key_pressed,
  input  logic [7:0] in_host_byte,
  input  logic       in_host_parity_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  kb_state_t                 st_r, st_nxt;
  kb_item_t                  item;
  kb_burst_t                 burst;
  logic [3:0]                delay_cfg_r;
  logic [MAX_BYTES-1:0][7:0] bytes_r;
  logic [1:0]                cnt_r;
  logic                      in_acc;
  logic                      out_acc;

  assign item = '{cmd:            in_cmd,
                  key_code:       in_key_code,
                  key_extended:   in_key_extended,
                  key_pressed:    in_key_pressed,
                  host_byte:      in_host_byte,
                  host_parity_ok: in_host_parity_ok};

  ps2kb_decode u_decode (
    .item         (item),
    .st           (st_r),
    .repeat_delay (delay_cfg_r),
    .st_nxt       (st_nxt),
    .burst        (burst)
  );

  assign out_valid       = cnt_r != 2'd0;
  assign out_byte        = bytes_r[0];
  assign out_last_of_run = cnt_r == 2'd1;
  assign out_acc         = out_valid && out_ready;
  assign in_ready        = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign in_acc          = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_cfg_r <= 4'd4;
    end else if (cfg_wr_en) begin
      delay_cfg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode:         TM_IDLE,
                delay_cnt:    4'd0,
                held_code:    8'h00,
                held_ext:     1'b0,
                last_code:    8'h00,
                last_ext:     1'b0,
                last_pressed: 1'b0,
                param_pend:   1'b0};
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_acc) begin
      cnt_r <= burst.cnt;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bytes_r <= burst.bytes;
    end else if (out_acc) begin
      bytes_r[0] <= bytes_r[1];
      bytes_r[1] <= bytes_r[2];
    end
  end

  // repeat state always enters with a cleared delay count
  a_repeat_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == TM_REPEAT |-> st_r.delay_cnt == 4'd0)
    else $error("delay count nonzero while repeating");

  // idle is reached only at reset or by the matching release, both of which clear the held code
  a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == TM_IDLE |-> st_r.held_code == 8'h00)
    else $error("held code kept while idle");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_acc)))
    else $error("transaction accepted over pending bytes");

  a_param_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_cmd == CMD_HOST && st_r.param_pend |=> !st_r.param_pend)
    else $error("parameter wait not cleared");

  a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r.mode))
    else $error("typematic mode not one-hot");

endmodule
